/* design/rlcs_pkg.sv */
`timescale 1ns / 1ps
package rlcs_pkg;

  localparam int NUM_PIXELS_DEF = 64;
  localparam int IDX_W = 6;
  localparam int COLOR_W = 8;
  localparam int CFG_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int PIXEL_W = 3 * COLOR_W;
  localparam int BIT_CNT_W = 5;
  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(PIXEL_W - 1);

  localparam logic [CFG_W-1:0] ONE_HIGH_RST = 8'd8;
  localparam logic [CFG_W-1:0] ONE_LOW_RST = 8'd4;
  localparam logic [CFG_W-1:0] ZERO_HIGH_RST = 8'd3;
  localparam logic [CFG_W-1:0] ZERO_LOW_RST = 8'd10;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_START = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ONE_HIGH  = 2'd0,
    CFG_ONE_LOW   = 2'd1,
    CFG_ZERO_HIGH = 2'd2,
    CFG_ZERO_LOW  = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_RUN,
    BK_FETCH,
    BK_READ
  } bk_state_t;

  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   idx;
    logic [PIXEL_W-1:0] rgb;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } bk_status_t;

endpackage

/* design/rlcs_front.sv */
`timescale 1ns / 1ps
module rlcs_front #(
  parameter int NUM_PIXELS = rlcs_pkg::NUM_PIXELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    op,
  input  logic [rlcs_pkg::IDX_W-1:0]    pixel_index,
  input  logic [rlcs_pkg::COLOR_W-1:0]  green_in,
  input  logic [rlcs_pkg::COLOR_W-1:0]  red_in,
  input  logic [rlcs_pkg::COLOR_W-1:0]  blue_in,
  input  rlcs_pkg::bk_status_t          status,
  output rlcs_pkg::q_head_t             head
);
  import rlcs_pkg::*;

  cmd_t        q [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic [1:0]  count_next;
  logic        push;
  logic        pop;
  cmd_t        cmd_in;

  // out-of-range pixels fold onto pixel 0
  always_comb begin
    cmd_in.op = op_t'(op);
    cmd_in.idx = (32'(pixel_index) < 32'(NUM_PIXELS)) ? pixel_index : '0;
    cmd_in.rgb = {green_in, red_in, blue_in};
  end

  assign busy = (count == 2'd2) || status.clearing;
  assign push = start && !busy;
  assign pop = status.pop && (count != 2'd0);

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  assign head.valid = (count != 2'd0);
  assign head.cmd = q[rd_ptr];

endmodule

/* design/rlcs_back.sv */
`timescale 1ns / 1ps
module rlcs_back #(
  parameter int NUM_PIXELS = rlcs_pkg::NUM_PIXELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rlcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rlcs_pkg::CFG_W-1:0]     cfg_data,
  input  rlcs_pkg::q_head_t              head,
  output rlcs_pkg::bk_status_t           status,
  output logic                           done,
  output logic                           line_level,
  output logic [rlcs_pkg::COLOR_W-1:0]   green_out,
  output logic [rlcs_pkg::COLOR_W-1:0]   red_out,
  output logic [rlcs_pkg::COLOR_W-1:0]   blue_out,
  output logic                           busy_res,
  output logic                           rejected
);
  import rlcs_pkg::*;

  localparam int AW = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
  localparam logic [AW-1:0] LAST_PIXEL = AW'(NUM_PIXELS - 1);

  logic [PIXEL_W-1:0] mem [NUM_PIXELS];
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  logic [PIXEL_W-1:0] mem_wd;
  logic [AW-1:0]      mem_ra;
  logic [PIXEL_W-1:0] rd_data;

  bk_state_t state;
  bk_state_t state_next;

  logic [CFG_W-1:0] one_high;
  logic [CFG_W-1:0] one_low;
  logic [CFG_W-1:0] zero_high;
  logic [CFG_W-1:0] zero_low;

  logic [AW-1:0]        clr_cnt;
  logic [AW-1:0]        clr_cnt_next;
  logic                 refreshing;
  logic                 refreshing_next;
  logic [AW-1:0]        pixel_counter;
  logic [AW-1:0]        pixel_counter_next;
  logic [BIT_CNT_W-1:0] bit_counter;
  logic [BIT_CNT_W-1:0] bit_counter_next;
  logic [PIXEL_W-1:0]   shift_word;
  logic [PIXEL_W-1:0]   shift_word_next;
  logic                 high_phase;
  logic                 high_phase_next;
  logic [CFG_W-1:0]     tick_counter;
  logic [CFG_W-1:0]     tick_counter_next;

  logic                 done_next;
  logic                 level_next;
  logic [PIXEL_W-1:0]   color_next;
  logic                 busy_res_next;
  logic                 rejected_next;

  logic                 cur_bit;
  logic [CFG_W-1:0]     limit_reg;
  logic [CFG_W:0]       limit;
  logic [CFG_W:0]       tick_inc;
  logic                 phase_done;
  logic [AW-1:0]        head_addr;
  logic                 level_now;

  assign head_addr = AW'({{AW{1'b0}}, head.cmd.idx});
  assign level_now = refreshing && high_phase;

  // a zero register means a full span of 256 ticks
  assign cur_bit = shift_word[PIXEL_W-1];
  always_comb begin
    if (high_phase) begin
      limit_reg = cur_bit ? one_high : zero_high;
    end else begin
      limit_reg = cur_bit ? one_low : zero_low;
    end
  end
  assign limit = {(limit_reg == '0), limit_reg};
  assign tick_inc = {1'b0, tick_counter} + (CFG_W+1)'(1);
  assign phase_done = !(tick_inc < limit);

  always_comb begin
    state_next = state;
    clr_cnt_next = clr_cnt;
    refreshing_next = refreshing;
    pixel_counter_next = pixel_counter;
    bit_counter_next = bit_counter;
    shift_word_next = shift_word;
    high_phase_next = high_phase;
    tick_counter_next = tick_counter;
    mem_we = 1'b0;
    mem_wa = head_addr;
    mem_wd = head.cmd.rgb;
    mem_ra = head_addr;
    status.pop = 1'b0;
    status.clearing = (state == BK_CLEAR);
    done_next = 1'b0;
    level_next = 1'b0;
    color_next = '0;
    busy_res_next = 1'b0;
    rejected_next = 1'b0;
    unique case (state)
      BK_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_cnt;
        mem_wd = '0;
        clr_cnt_next = clr_cnt + AW'(1);
        if (clr_cnt == LAST_PIXEL) begin
          state_next = BK_RUN;
        end
      end
      BK_FETCH: begin
        shift_word_next = rd_data;
        state_next = BK_RUN;
      end
      BK_READ: begin
        done_next = 1'b1;
        level_next = level_now;
        color_next = rd_data;
        busy_res_next = refreshing;
      end
      BK_RUN: begin
        if (head.valid) begin
          status.pop = 1'b1;
          level_next = level_now;
          done_next = 1'b1;
          unique case (head.cmd.op)
            OP_TICK: begin
              if (refreshing) begin
                if (!phase_done) begin
                  tick_counter_next = tick_inc[CFG_W-1:0];
                end else begin
                  tick_counter_next = '0;
                  if (high_phase) begin
                    high_phase_next = 1'b0;
                  end else begin
                    high_phase_next = 1'b1;
                    if (bit_counter != LAST_BIT) begin
                      bit_counter_next = bit_counter + BIT_CNT_W'(1);
                      shift_word_next = {shift_word[PIXEL_W-2:0], 1'b0};
                    end else begin
                      bit_counter_next = '0;
                      if (pixel_counter != LAST_PIXEL) begin
                        pixel_counter_next = pixel_counter + AW'(1);
                        mem_ra = pixel_counter + AW'(1);
                        state_next = BK_FETCH;
                      end else begin
                        pixel_counter_next = '0;
                        shift_word_next = '0;
                        refreshing_next = 1'b0;
                      end
                    end
                  end
                end
              end
            end
            OP_WRITE: begin
              if (refreshing) begin
                rejected_next = 1'b1;
              end else begin
                mem_we = 1'b1;
              end
            end
            OP_READ: begin
              done_next = 1'b0;
              level_next = 1'b0;
              state_next = BK_READ;
            end
            OP_START: begin
              if (refreshing) begin
                rejected_next = 1'b1;
              end else begin
                refreshing_next = 1'b1;
                pixel_counter_next = '0;
                bit_counter_next = '0;
                high_phase_next = 1'b1;
                tick_counter_next = '0;
                mem_ra = '0;
                state_next = BK_FETCH;
              end
            end
          endcase
          busy_res_next = done_next && refreshing_next;
        end
      end
    endcase
    if (state == BK_READ) begin
      state_next = BK_RUN;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      one_high <= ONE_HIGH_RST;
      one_low <= ONE_LOW_RST;
      zero_high <= ZERO_HIGH_RST;
      zero_low <= ZERO_LOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ONE_HIGH:  one_high <= cfg_data;
        CFG_ONE_LOW:   one_low <= cfg_data;
        CFG_ZERO_HIGH: zero_high <= cfg_data;
        CFG_ZERO_LOW:  zero_low <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_CLEAR;
      clr_cnt <= '0;
      refreshing <= 1'b0;
      pixel_counter <= '0;
      bit_counter <= '0;
      shift_word <= '0;
      high_phase <= 1'b1;
      tick_counter <= '0;
      done <= 1'b0;
      line_level <= 1'b0;
      green_out <= '0;
      red_out <= '0;
      blue_out <= '0;
      busy_res <= 1'b0;
      rejected <= 1'b0;
    end else begin
      state <= state_next;
      clr_cnt <= clr_cnt_next;
      refreshing <= refreshing_next;
      pixel_counter <= pixel_counter_next;
      bit_counter <= bit_counter_next;
      shift_word <= shift_word_next;
      high_phase <= high_phase_next;
      tick_counter <= tick_counter_next;
      done <= done_next;
      line_level <= level_next;
      green_out <= color_next[PIXEL_W-1 -: COLOR_W];
      red_out <= color_next[COLOR_W +: COLOR_W];
      blue_out <= color_next[COLOR_W-1:0];
      busy_res <= busy_res_next;
      rejected <= rejected_next;
    end
  end

endmodule

/* design/rgb_led_chain_serializer.sv */
`timescale 1ns / 1ps
// rgb led chain serializer: pixel store and pulse-width single-wire line
// requests: present op, pixel_index and colors with start; a request is
//   taken at a clock edge where start is high and busy is low
// results: one per request, shown for one cycle with done high; the
//   receiver cannot stall, so no result is ever held back
// config: cfg_we with cfg_index and cfg_data writes a tick count at once
// throughput: one request per cycle, but the sequencer stalls in an extra state
//   for each read, each accepted start and each tick that moves to the next pixel, set by
//   the single read port of the pixel memory
// a two-entry request queue sits between the front and the sequencer;
//   busy rises when it is full
// reset: tick counts return to 8, 4, 3, 10 and the line goes idle low;
//   the pixel memory is then cleared one pixel a cycle, and busy stays high
//   until every pixel is cleared (config writes are still taken)
module rgb_led_chain_serializer #(
  parameter int NUM_PIXELS = rlcs_pkg::NUM_PIXELS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     op,
  input  logic [rlcs_pkg::IDX_W-1:0]     pixel_index,
  input  logic [rlcs_pkg::COLOR_W-1:0]   green_in,
  input  logic [rlcs_pkg::COLOR_W-1:0]   red_in,
  input  logic [rlcs_pkg::COLOR_W-1:0]   blue_in,
  output logic                           done,
  output logic                           line_level,
  output logic [rlcs_pkg::COLOR_W-1:0]   green_out,
  output logic [rlcs_pkg::COLOR_W-1:0]   red_out,
  output logic [rlcs_pkg::COLOR_W-1:0]   blue_out,
  output logic                           busy_res,
  output logic                           rejected,
  input  logic                           cfg_we,
  input  logic [rlcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rlcs_pkg::CFG_W-1:0]     cfg_data
);
  import rlcs_pkg::*;

  q_head_t    head;
  bk_status_t status;

  rlcs_front #(
    .NUM_PIXELS(NUM_PIXELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .pixel_index(pixel_index),
    .green_in   (green_in),
    .red_in     (red_in),
    .blue_in    (blue_in),
    .status     (status),
    .head       (head)
  );

  rlcs_back #(
    .NUM_PIXELS(NUM_PIXELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .status    (status),
    .done      (done),
    .line_level(line_level),
    .green_out (green_out),
    .red_out   (red_out),
    .blue_out  (blue_out),
    .busy_res  (busy_res),
    .rejected  (rejected)
  );

`ifndef SYNTH
  // a rejection only happens mid-refresh and does not end it
  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    done && rejected |-> busy_res)
    else $error("rejected request outside a refresh");

  // a refresh ends only from a low phase
  a_high_busy: assert property (@(posedge clk) disable iff (rst)
    done && line_level |-> busy_res)
    else $error("line high on the result that ends a refresh");

  // result fields stay quiet between results
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    !done |-> !line_level && !rejected && !busy_res)
    else $error("result fields active without done");
`endif

endmodule

/* sim/rgb_led_chain_serializer_test.sv */
`timescale 1ns / 1ps
module rgb_led_chain_serializer_test;
  import rlcs_pkg::*;

  localparam int NPIX = NUM_PIXELS_DEF;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    logic               line_level;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] blue;
    logic               busy_res;
    logic               rejected;
  } chain_out_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [1:0]           op;
  logic [IDX_W-1:0]     pixel_index;
  logic [COLOR_W-1:0]   green_in;
  logic [COLOR_W-1:0]   red_in;
  logic [COLOR_W-1:0]   blue_in;
  logic                 done;
  logic                 line_level;
  logic [COLOR_W-1:0]   green_out;
  logic [COLOR_W-1:0]   red_out;
  logic [COLOR_W-1:0]   blue_out;
  logic                 busy_res;
  logic                 rejected;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // shadow of the serializer state
  logic [PIXEL_W-1:0] pix_mem [NPIX];
  logic [CFG_W-1:0]   tick_reg [4];
  logic               refresh_on;
  int                 pix_ptr;
  int                 bit_ptr;
  logic [PIXEL_W-1:0] shift_reg;
  logic               in_high;
  int                 tick_cnt;

  chain_out_t chain_outputs[$];
  int idle_pct;
  int fail_cnt;
  int sent_cnt;
  int results_seen;
  int rejected_cnt;
  int refreshes_done;
  int quiet_cycles;

  rgb_led_chain_serializer #(
    .NUM_PIXELS(NPIX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .pixel_index(pixel_index),
    .green_in(green_in),
    .red_in(red_in),
    .blue_in(blue_in),
    .done(done),
    .line_level(line_level),
    .green_out(green_out),
    .red_out(red_out),
    .blue_out(blue_out),
    .busy_res(busy_res),
    .rejected(rejected),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic chain_out_t chain_step(op_t kind, logic [IDX_W-1:0] idx,
                                            logic [COLOR_W-1:0] g, r, b);
    chain_out_t res;
    logic       lit;
    cfg_idx_t   sel;
    int         limit;
    res = '0;
    res.line_level = refresh_on && in_high;
    case (kind)
      OP_TICK: begin
        if (refresh_on) begin
          lit = shift_reg[PIXEL_W-1];
          if (in_high) sel = lit ? CFG_ONE_HIGH : CFG_ZERO_HIGH;
          else sel = lit ? CFG_ONE_LOW : CFG_ZERO_LOW;
          limit = (tick_reg[sel] == '0) ? 256 : int'(tick_reg[sel]);
          if (tick_cnt + 1 < limit) begin
            tick_cnt++;
          end else begin
            tick_cnt = 0;
            if (in_high) begin
              in_high = 1'b0;
            end else begin
              in_high = 1'b1;
              if (bit_ptr + 1 < PIXEL_W) begin
                bit_ptr++;
                shift_reg = shift_reg << 1;
              end else begin
                bit_ptr = 0;
                if (pix_ptr + 1 < NPIX) begin
                  pix_ptr++;
                  shift_reg = pix_mem[pix_ptr];
                end else begin
                  pix_ptr = 0;
                  shift_reg = '0;
                  refresh_on = 1'b0;
                  refreshes_done++;
                end
              end
            end
          end
        end
      end
      OP_WRITE: begin
        if (refresh_on) res.rejected = 1'b1;
        else pix_mem[idx] = {g, r, b};
      end
      OP_READ: begin
        {res.green, res.red, res.blue} = pix_mem[idx];
      end
      default: begin
        if (refresh_on) begin
          res.rejected = 1'b1;
        end else begin
          refresh_on = 1'b1;
          pix_ptr = 0;
          bit_ptr = 0;
          shift_reg = pix_mem[0];
          in_high = 1'b1;
          tick_cnt = 0;
        end
      end
    endcase
    res.busy_res = refresh_on;
    if (res.rejected) rejected_cnt++;
    return res;
  endfunction

  task automatic send_request(op_t kind, logic [IDX_W-1:0] idx,
                              logic [COLOR_W-1:0] g, r, b);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    op = kind;
    pixel_index = idx;
    green_in = g;
    red_in = r;
    blue_in = b;
    start = 1'b1;
    do @(posedge clk); while (busy);
    chain_outputs.push_back(chain_step(kind, idx, g, r, b));
    sent_cnt++;
    @(negedge clk);
  endtask

  // low pixel indexes get most writes so the refresh shows them early
  task automatic send_op(op_t kind);
    logic [IDX_W-1:0] idx;
    idx = $urandom_range(1) ? IDX_W'($urandom_range(3)) : IDX_W'($urandom_range(NPIX - 1));
    send_request(kind, idx, COLOR_W'($urandom_range(255)), COLOR_W'($urandom_range(255)),
                 COLOR_W'($urandom_range(255)));
  endtask

  task automatic settle();
    start = 1'b0;
    while (chain_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_ticks(logic [CFG_W-1:0] one_hi, one_lo, zero_hi, zero_lo);
    logic [CFG_W-1:0] vals [4];
    settle();
    vals = '{one_hi, one_lo, zero_hi, zero_lo};
    for (int i = 0; i < 4; i++) begin
      cfg_we = 1'b1;
      cfg_index = cfg_idx_t'(i);
      cfg_data = vals[i];
      @(posedge clk);
      tick_reg[i] = vals[i];
      @(negedge clk);
      cfg_we = 1'b0;
    end
  endtask

  task automatic finish_refresh();
    set_ticks(8'd1, 8'd1, 8'd1, 8'd1);
    while (refresh_on) send_op($urandom_range(19) == 0 ? OP_READ : OP_TICK);
  endtask

  task automatic test_store_extremes();
    send_request(OP_READ, 6'd0, 8'hff, 8'hff, 8'hff);
    send_request(OP_READ, 6'd63, 8'h00, 8'h00, 8'h00);
    send_request(OP_TICK, 6'd63, 8'hff, 8'hff, 8'hff);
    send_request(OP_WRITE, 6'd63, 8'hff, 8'hff, 8'hff);
    send_request(OP_WRITE, 6'd0, 8'h80, 8'h00, 8'h01);
    send_request(OP_WRITE, 6'd1, 8'h55, 8'haa, 8'h0f);
    send_request(OP_WRITE, 6'd2, 8'h00, 8'hff, 8'h00);
    send_request(OP_READ, 6'd63, 8'h00, 8'h00, 8'h00);
    send_request(OP_READ, 6'd0, 8'hff, 8'hff, 8'hff);
    send_request(OP_READ, 6'd1, 8'h00, 8'h00, 8'h00);
    send_request(OP_READ, 6'd2, 8'h00, 8'h00, 8'h00);
    send_request(OP_READ, 6'd5, 8'h00, 8'h00, 8'h00);
  endtask

  // zero count means 256 ticks, then a count cut below the ticks already spent
  task automatic test_refresh_corners();
    set_ticks(8'd0, 8'd1, 8'd2, 8'd1);
    send_request(OP_START, 6'd7, 8'h12, 8'h34, 8'h56);
    send_request(OP_START, 6'd0, 8'h00, 8'h00, 8'h00);
    send_request(OP_WRITE, 6'd0, 8'hff, 8'hff, 8'hff);
    send_request(OP_READ, 6'd63, 8'h00, 8'h00, 8'h00);
    repeat (100) send_op(OP_TICK);
    set_ticks(8'd50, 8'd1, 8'd2, 8'd1);
    repeat (4) send_op(OP_TICK);
    send_request(OP_READ, 6'd0, 8'h00, 8'h00, 8'h00);
    repeat (260) send_op(OP_TICK);
  endtask

  task automatic test_full_refresh();
    finish_refresh();
    send_request(OP_TICK, 6'd0, 8'h00, 8'h00, 8'h00);
    send_request(OP_WRITE, 6'd0, 8'h3c, 8'hc3, 8'h99);
    send_request(OP_READ, 6'd0, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_random_traffic(int pct, int count,
                                     logic [CFG_W-1:0] one_hi, one_lo, zero_hi, zero_lo);
    int  roll;
    op_t kind;
    idle_pct = pct;
    set_ticks(one_hi, one_lo, zero_hi, zero_lo);
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (refresh_on)
        kind = roll < 80 ? OP_TICK : roll < 88 ? OP_READ : roll < 94 ? OP_WRITE : OP_START;
      else
        kind = roll < 55 ? OP_WRITE : roll < 78 ? OP_READ : roll < 90 ? OP_TICK : OP_START;
      send_op(kind);
    end
    finish_refresh();
  endtask

  always @(posedge clk) begin
    chain_out_t want;
    if (!rst && done) begin
      results_seen++;
      if (chain_outputs.size() == 0) begin
        $error("result with no pending request");
        fail_cnt++;
      end else begin
        want = chain_outputs.pop_front();
        if (line_level !== want.line_level) begin
          $error("line_level expected %0h got %0h", want.line_level, line_level);
          fail_cnt++;
        end
        if (green_out !== want.green) begin
          $error("green_out expected %0h got %0h", want.green, green_out);
          fail_cnt++;
        end
        if (red_out !== want.red) begin
          $error("red_out expected %0h got %0h", want.red, red_out);
          fail_cnt++;
        end
        if (blue_out !== want.blue) begin
          $error("blue_out expected %0h got %0h", want.blue, blue_out);
          fail_cnt++;
        end
        if (busy_res !== want.busy_res) begin
          $error("busy_res expected %0h got %0h", want.busy_res, busy_res);
          fail_cnt++;
        end
        if (rejected !== want.rejected) begin
          $error("rejected expected %0h got %0h", want.rejected, rejected);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    op = OP_TICK;
    pixel_index = '0;
    green_in = '0;
    red_in = '0;
    blue_in = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_ONE_HIGH;
    cfg_data = '0;
    idle_pct = 0;
    fail_cnt = 0;
    sent_cnt = 0;
    results_seen = 0;
    rejected_cnt = 0;
    refreshes_done = 0;
    quiet_cycles = 0;
    foreach (pix_mem[i]) pix_mem[i] = '0;
    tick_reg = '{ONE_HIGH_RST, ONE_LOW_RST, ZERO_HIGH_RST, ZERO_LOW_RST};
    refresh_on = 1'b0;
    pix_ptr = 0;
    bit_ptr = 0;
    shift_reg = '0;
    in_high = 1'b1;
    tick_cnt = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_store_extremes();
    test_refresh_corners();
    test_full_refresh();
    test_random_traffic(25, 320, COLOR_W'($urandom_range(3, 1)), COLOR_W'($urandom_range(3, 1)),
                        COLOR_W'($urandom_range(3, 1)), COLOR_W'($urandom_range(3, 1)));
    test_random_traffic(63, 320, 8'd1, 8'd255, 8'd2, 8'd1);
    test_random_traffic(0, 320, COLOR_W'($urandom_range(4, 1)), COLOR_W'($urandom_range(4, 1)),
                        COLOR_W'($urandom_range(4, 1)), COLOR_W'($urandom_range(4, 1)));
    settle();

    $display("sent %0d requests, checked %0d results, %0d of them rejected",
             sent_cnt, results_seen, rejected_cnt);
    $display("%0d complete refreshes, tick counts from 1 to 256, sender gaps at 25/63/0 pct",
             refreshes_done);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
